FILE: rtl/rtu_frame_receiver_checker_core_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef RTU_FRAME_RECEIVER_CHECKER_CORE_ASSERT_SVH
`define RTU_FRAME_RECEIVER_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define RFC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define RFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");
`else
`define RFC_ASSERT_IMPL(lbl, ante, cons)
`define RFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/rtu_frc_pkg.sv
// Types and constants of the serial frame receiver and checker.
package rtu_frc_pkg;

    // One input item: a received byte or one idle tick.
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_rx_item;

    // One verdict for a closed frame.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  function_code;
        logic [39:0] payload;
        logic [5:0]  bytes_seen;
    } t_verdict;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
    localparam logic [1:0] ST_BAD_CRC   = 2'd3;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TICKS   = 1'b1;

    localparam logic [7:0]  STATION_RESET = 8'd16;
    localparam logic [15:0] SILENCE_RESET = 16'd4000;

    localparam logic [5:0]  ADDR_POS   = 6'd0;
    localparam logic [5:0]  FUNC_POS   = 6'd1;
    localparam logic [5:0]  CRC_LEN    = 6'd7;
    localparam logic [5:0]  CRC_HI_POS = 6'd8;
    localparam logic [5:0]  FRAME_LEN  = 6'd9;
    localparam logic [5:0]  COUNT_MAX  = 6'd63;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

endpackage

FILE: rtl/rtu_frc_crc.sv
// CRC-16/MODBUS update of the running value by one byte, LSB first.
module rtu_frc_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import rtu_frc_pkg::*;

    always_comb begin
        logic [15:0] v;
        v = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

FILE: rtl/rtu_frame_receiver_checker_core.sv
// Serial request frame receiver: byte counting, CRC-16/MODBUS check, verdict on silence.
//
// Each transfer on the input channel is either a received byte or one idle tick of
// one microsecond. The first nine bytes of a frame are kept (address, function code,
// five payload bytes, little-endian CRC) and the CRC runs over the first seven. Once
// the ticks after the last byte reach silence_ticks, one verdict transfer leaves on
// the output channel. One item can be accepted in every clock unless the input stalls;
// the state registers are updated at the accepting edge and the verdict sits in
// a two-entry output buffer, so the input stalls only while both entries are held by
// a stalled output. The byte-wide CRC update is the longest combinational path.
`include "rtu_frame_receiver_checker_core_assert.svh"

module rtu_frame_receiver_checker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [rtu_frc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rtu_frc_pkg::t_rx_item               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rtu_frc_pkg::t_verdict               o_out_data
);
    import rtu_frc_pkg::*;

    logic [7:0]  r_station;
    logic [15:0] r_silence;

    logic [5:0]  r_byte_cnt, n_byte_cnt;
    logic [15:0] r_idle_cnt, n_idle_cnt;
    logic [15:0] r_crc, n_crc;

    logic [7:0]  r_addr, r_func, r_crc_lo, r_crc_hi;
    logic [39:0] r_payload;

    logic     r_out_valid, r_skd_valid;
    t_verdict r_out, r_skd;

    logic        accept, is_byte, is_tick, close, out_free;
    logic [15:0] idle_inc, crc_next;
    t_verdict    verdict;

    rtu_frc_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (i_in_data.rx_byte),
        .o_crc  (crc_next)
    );

    assign o_in_stall = r_skd_valid;
    assign accept     = i_in_valid & ~o_in_stall;
    assign is_byte    = accept & (i_in_data.op == OP_BYTE);
    assign is_tick    = accept & (i_in_data.op == OP_TICK) & (r_byte_cnt != 6'd0);
    assign idle_inc   = (r_idle_cnt == 16'hFFFF) ? r_idle_cnt : r_idle_cnt + 16'd1;
    assign close      = is_tick & (idle_inc >= r_silence);

    // Verdict checks in priority order: length, then address, then CRC.
    always_comb begin
        verdict.function_code = 8'h00;
        verdict.payload       = 40'h0;
        verdict.bytes_seen    = r_byte_cnt;
        if (r_byte_cnt < FRAME_LEN) begin
            verdict.status = ST_SHORT;
        end else if (r_addr != r_station) begin
            verdict.status = ST_BAD_ADDR;
        end else if (r_crc != {r_crc_hi, r_crc_lo}) begin
            verdict.status = ST_BAD_CRC;
        end else begin
            verdict.status        = ST_VALID;
            verdict.function_code = r_func;
            verdict.payload       = r_payload;
        end
    end

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_idle_cnt = r_idle_cnt;
        n_crc      = r_crc;
        if (is_byte) begin
            n_idle_cnt = 16'd0;
            if (r_byte_cnt < CRC_LEN) begin
                n_crc = crc_next;
            end
            if (r_byte_cnt < COUNT_MAX) begin
                n_byte_cnt = r_byte_cnt + 6'd1;
            end
        end else if (close) begin
            n_byte_cnt = 6'd0;
            n_idle_cnt = 16'd0;
            n_crc      = CRC_INIT;
        end else if (is_tick) begin
            n_idle_cnt = idle_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station  <= STATION_RESET;
            r_silence  <= SILENCE_RESET;
            r_byte_cnt <= 6'd0;
            r_idle_cnt <= 16'd0;
            r_crc      <= CRC_INIT;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_STATION_ADDRESS: r_station <= i_cfg_wdata[7:0];
                    REG_SILENCE_TICKS:   r_silence <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_byte_cnt <= n_byte_cnt;
            r_idle_cnt <= n_idle_cnt;
            r_crc      <= n_crc;
        end
    end

    // Frame bytes by position; later bytes are counted only.
    always_ff @(posedge i_clk) begin
        if (is_byte) begin
            if (r_byte_cnt == ADDR_POS) begin
                r_addr <= i_in_data.rx_byte;
            end else if (r_byte_cnt == FUNC_POS) begin
                r_func <= i_in_data.rx_byte;
            end else if (r_byte_cnt < CRC_LEN) begin
                r_payload <= {r_payload[31:0], i_in_data.rx_byte};
            end else if (r_byte_cnt == CRC_LEN) begin
                r_crc_lo <= i_in_data.rx_byte;
            end else if (r_byte_cnt == CRC_HI_POS) begin
                r_crc_hi <= i_in_data.rx_byte;
            end
        end
    end

    // Output register with a skid entry behind it.
    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skd_valid) begin
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_out_valid <= close;
                end
            end else if (close) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
            end else if (close) begin
                r_out <= verdict;
            end
        end else if (close) begin
            r_skd <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RFC_ASSERT_IMPL(a_skid_behind_out, r_skd_valid, r_out_valid)
    `RFC_ASSERT_NEXT(a_close_clears_count, close, (r_byte_cnt == 6'd0) && (r_crc == CRC_INIT))
    `RFC_ASSERT_IMPL(a_idle_needs_bytes, r_idle_cnt != 16'd0, r_byte_cnt != 6'd0)
    `RFC_ASSERT_IMPL(a_valid_full_frame, r_out_valid && (r_out.status == ST_VALID), r_out.bytes_seen >= FRAME_LEN)

endmodule
